// File: rtl/tls12ht_pkg.sv
// shared types and constants of the tls 1.2 handshake tracker
package tls12ht_pkg;

  // request kinds
  typedef enum logic [1:0] {
    REQ_HS      = 2'd0,
    REQ_CCS     = 2'd1,
    REQ_RESTART = 2'd2
  } req_type_e;

  // handshake phases
  localparam logic [3:0] PH_INIT      = 4'd0;
  localparam logic [3:0] PH_CH_SENT   = 4'd1;
  localparam logic [3:0] PH_SH_RECV   = 4'd2;
  localparam logic [3:0] PH_CERT_RECV = 4'd3;
  localparam logic [3:0] PH_SKE_RECV  = 4'd4;
  localparam logic [3:0] PH_CR_RECV   = 4'd5;
  localparam logic [3:0] PH_SHD_RECV  = 4'd6;
  localparam logic [3:0] PH_CERT_SENT = 4'd7;
  localparam logic [3:0] PH_CV_SENT   = 4'd8;
  localparam logic [3:0] PH_CKE_SENT  = 4'd9;
  localparam logic [3:0] PH_CCS_SENT  = 4'd10;
  localparam logic [3:0] PH_FIN_SENT  = 4'd11;
  localparam logic [3:0] PH_CCS_RECV  = 4'd12;
  localparam logic [3:0] PH_FIN_RECV  = 4'd13;
  localparam logic [3:0] PH_COMPLETE  = 4'd14;
  localparam logic [3:0] PH_ERROR     = 4'd15;

  // rfc 5246 handshake type codes
  localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;
  localparam logic [7:0] HS_SERVER_HELLO = 8'd2;
  localparam logic [7:0] HS_SESSION_TKT  = 8'd4;
  localparam logic [7:0] HS_CERTIFICATE  = 8'd11;
  localparam logic [7:0] HS_SERVER_KEX   = 8'd12;
  localparam logic [7:0] HS_CERT_REQUEST = 8'd13;
  localparam logic [7:0] HS_SERVER_DONE  = 8'd14;
  localparam logic [7:0] HS_CERT_VERIFY  = 8'd15;
  localparam logic [7:0] HS_CLIENT_KEX   = 8'd16;
  localparam logic [7:0] HS_FINISHED     = 8'd20;

  typedef struct packed {
    logic [1:0] req_type;
    logic       from_server;
    logic [7:0] handshake_code;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] phase;
    logic       legal_event;
  } step_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       legal_event;
    logic       in_error;
    logic       done_res;
  } res_t;

endpackage

// File: rtl/tls12ht_if.sv
// request and result channel interfaces of the handshake tracker
interface tls12ht_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       from_server;
  logic [7:0] handshake_code;

  modport source (output valid, req_type, from_server, handshake_code, input ready);
  modport sink (input valid, req_type, from_server, handshake_code, output ready);
endinterface

interface tls12ht_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] phase;
  logic       legal_event;
  logic       in_error;
  logic       done_res;

  modport source (output valid, phase, legal_event, in_error, done_res, input ready);
  modport sink (input valid, phase, legal_event, in_error, done_res, output ready);
endinterface

// File: rtl/tls12ht_next.sv
// next-phase lookup for one observed request
module tls12ht_next (
  input  logic [3:0]            phase_i,
  input  tls12ht_pkg::item_t    item_i,
  output logic [3:0]            phase_o,
  output logic                  legal_o
);

  // change cipher spec rule, returns {legal, next phase}
  function automatic logic [4:0] ccs_rule(input logic [3:0] ph, input logic srv);
    logic [3:0] nx;
    nx = tls12ht_pkg::PH_ERROR;
    if (ph == tls12ht_pkg::PH_FIN_SENT && srv) begin
      nx = tls12ht_pkg::PH_CCS_RECV;
    end else if (ph == tls12ht_pkg::PH_CKE_SENT && !srv) begin
      nx = tls12ht_pkg::PH_CCS_SENT;
    end else if (ph == tls12ht_pkg::PH_CCS_SENT && !srv) begin
      nx = tls12ht_pkg::PH_FIN_SENT;
    end else if (ph == tls12ht_pkg::PH_CCS_RECV && srv) begin
      nx = tls12ht_pkg::PH_FIN_RECV;
    end else if (ph == tls12ht_pkg::PH_FIN_RECV) begin
      nx = tls12ht_pkg::PH_COMPLETE;
    end
    return {nx != tls12ht_pkg::PH_ERROR, nx};
  endfunction

  logic [4:0] ccs_res;
  logic [3:0] hs_nx;
  logic       srv;
  logic [7:0] code;
  logic [3:0] ph;

  assign srv  = item_i.from_server;
  assign code = item_i.handshake_code;
  assign ph   = phase_i;

  assign ccs_res = ccs_rule(ph, srv);

  // plain handshake message table
  always_comb begin
    hs_nx = tls12ht_pkg::PH_ERROR;
    if (srv) begin
      if (ph == tls12ht_pkg::PH_CH_SENT && code == tls12ht_pkg::HS_SERVER_HELLO) begin
        hs_nx = tls12ht_pkg::PH_SH_RECV;
      end else if (ph == tls12ht_pkg::PH_SH_RECV && code == tls12ht_pkg::HS_CERTIFICATE) begin
        hs_nx = tls12ht_pkg::PH_CERT_RECV;
      end else if ((ph == tls12ht_pkg::PH_SH_RECV || ph == tls12ht_pkg::PH_CERT_RECV) &&
                   code == tls12ht_pkg::HS_SERVER_KEX) begin
        hs_nx = tls12ht_pkg::PH_SKE_RECV;
      end else if ((ph == tls12ht_pkg::PH_SH_RECV || ph == tls12ht_pkg::PH_CERT_RECV ||
                    ph == tls12ht_pkg::PH_SKE_RECV) &&
                   code == tls12ht_pkg::HS_CERT_REQUEST) begin
        hs_nx = tls12ht_pkg::PH_CR_RECV;
      end else if ((ph == tls12ht_pkg::PH_SH_RECV || ph == tls12ht_pkg::PH_CERT_RECV ||
                    ph == tls12ht_pkg::PH_SKE_RECV || ph == tls12ht_pkg::PH_CR_RECV) &&
                   code == tls12ht_pkg::HS_SERVER_DONE) begin
        hs_nx = tls12ht_pkg::PH_SHD_RECV;
      end else if (ph == tls12ht_pkg::PH_FIN_SENT && code == tls12ht_pkg::HS_FINISHED) begin
        hs_nx = tls12ht_pkg::PH_FIN_RECV;
      end else if (ph == tls12ht_pkg::PH_FIN_SENT && code == tls12ht_pkg::HS_SESSION_TKT) begin
        hs_nx = tls12ht_pkg::PH_FIN_SENT;
      end
    end else begin
      if (ph == tls12ht_pkg::PH_INIT && code == tls12ht_pkg::HS_CLIENT_HELLO) begin
        hs_nx = tls12ht_pkg::PH_CH_SENT;
      end else if (ph == tls12ht_pkg::PH_SHD_RECV && code == tls12ht_pkg::HS_CERTIFICATE) begin
        hs_nx = tls12ht_pkg::PH_CERT_SENT;
      end else if ((ph == tls12ht_pkg::PH_SHD_RECV || ph == tls12ht_pkg::PH_CERT_SENT ||
                    ph == tls12ht_pkg::PH_CV_SENT) &&
                   code == tls12ht_pkg::HS_CLIENT_KEX) begin
        hs_nx = tls12ht_pkg::PH_CKE_SENT;
      end else if (ph == tls12ht_pkg::PH_CERT_SENT && code == tls12ht_pkg::HS_CERT_VERIFY) begin
        hs_nx = tls12ht_pkg::PH_CV_SENT;
      end else if (ph == tls12ht_pkg::PH_CKE_SENT && code == tls12ht_pkg::HS_FINISHED) begin
        hs_nx = tls12ht_pkg::PH_FIN_SENT;
      end
    end
  end

  always_comb begin
    phase_o = ph;
    legal_o = 1'b0;
    case (item_i.req_type)
      tls12ht_pkg::REQ_HS: begin
        // encrypted finished goes through the ccs rule
        if ((ph == tls12ht_pkg::PH_CCS_SENT && !srv) ||
            (ph == tls12ht_pkg::PH_CCS_RECV && srv)) begin
          phase_o = ccs_res[3:0];
          legal_o = ccs_res[4];
        end else begin
          phase_o = hs_nx;
          legal_o = (hs_nx != tls12ht_pkg::PH_ERROR);
        end
      end
      tls12ht_pkg::REQ_CCS: begin
        phase_o = ccs_res[3:0];
        legal_o = ccs_res[4];
      end
      tls12ht_pkg::REQ_RESTART: begin
        phase_o = tls12ht_pkg::PH_INIT;
        legal_o = 1'b1;
      end
      default: begin
        phase_o = ph;
        legal_o = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/tls12ht_out_stage.sv
// phase register and result register with output handshake
module tls12ht_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tls12ht_pkg::step_t  step_i,
  output logic                step_ready_o,
  output logic [3:0]          phase_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output tls12ht_pkg::res_t   res_o
);

  logic              res_valid_q;
  logic [3:0]        phase_q;
  tls12ht_pkg::res_t res_q;
  logic              take;

  assign step_ready_o = !res_valid_q || res_ready_i;
  assign take         = step_i.valid && step_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      phase_q     <= tls12ht_pkg::PH_INIT;
    end else begin
      if (take) begin
        res_valid_q <= 1'b1;
        phase_q     <= step_i.phase;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.phase       <= step_i.phase;
      res_q.legal_event <= step_i.legal_event;
      res_q.in_error    <= (step_i.phase == tls12ht_pkg::PH_ERROR);
      res_q.done_res    <= (step_i.phase == tls12ht_pkg::PH_COMPLETE);
    end
  end

  assign phase_o     = phase_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/tls12_handshake_tracker.sv
// top level of the tls 1.2 handshake tracker
// passive monitor of one tls 1.2 handshake: each request on req_i is a
// handshake message (direction and rfc 5246 type byte), a change cipher spec
// record (direction) or a restart, and produces exactly one result on res_o
// with the new phase, whether the event was legal, an error flag and a
// complete flag. any illegal handshake or change cipher spec event parks
// the tracker in the sticky error phase, which only a restart leaves.
// throughput is one request per clock while res_o is not stalled. a
// request accepted into the input register moves on to the result
// register (input register, then result register) when the result stage
// can take it. the loop through the phase register and the next-phase
// table sets the rate. a result that waits on res_o stalls the table: the
// input register still takes one more request, then req_i.ready drops
// until res_o.ready returns.
module tls12_handshake_tracker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tls12ht_req_if.sink          req_i,
  tls12ht_res_if.source        res_o
);

  // input register
  logic                in_valid_q;
  tls12ht_pkg::item_t  item_q;

  // lookup and result stage
  logic [3:0]          phase_cur;
  logic [3:0]          phase_nx;
  logic                legal_nx;
  logic                step_ready;
  tls12ht_pkg::step_t  step;
  tls12ht_pkg::res_t   res;

  // the input register frees up when its request moves to the result stage
  assign req_i.ready = !in_valid_q || step_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      item_q.req_type       <= req_i.req_type;
      item_q.from_server    <= req_i.from_server;
      item_q.handshake_code <= req_i.handshake_code;
    end
  end

  // phase transition table, evaluated against the live phase register
  tls12ht_next u_next (
    .phase_i (phase_cur),
    .item_i  (item_q),
    .phase_o (phase_nx),
    .legal_o (legal_nx)
  );

  assign step.valid       = in_valid_q;
  assign step.phase       = phase_nx;
  assign step.legal_event = legal_nx;

  tls12ht_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .step_ready_o (step_ready),
    .phase_o      (phase_cur),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res)
  );

  assign res_o.phase       = res.phase;
  assign res_o.legal_event = res.legal_event;
  assign res_o.in_error    = res.in_error;
  assign res_o.done_res    = res.done_res;

endmodule

// File: tb/tls12ht_phase_checker.sv
// phase predictor and result checker for the tls 1.2 handshake tracker
`timescale 1ns / 100ps

module tls12ht_phase_checker
  import tls12ht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tls12ht_req_if      req_i,
  tls12ht_res_if      res_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o,
  output int unsigned checked_cnt_o,
  output int unsigned legal_cnt_o,
  output logic [15:0] phases_hit_o
);

  logic [3:0]  track_phase;
  res_t        predicted_outcomes[$];
  int unsigned errs;
  int unsigned checked;
  int unsigned legal;
  logic [15:0] hits;

  // change cipher spec rule, PH_ERROR when not allowed
  function automatic logic [3:0] ccs_step(logic [3:0] cur, logic srv);
    if (cur == PH_FIN_SENT && srv) return PH_CCS_RECV;
    if (cur == PH_CKE_SENT && !srv) return PH_CCS_SENT;
    if (cur == PH_CCS_SENT && !srv) return PH_FIN_SENT;
    if (cur == PH_CCS_RECV && srv) return PH_FIN_RECV;
    if (cur == PH_FIN_RECV) return PH_COMPLETE;
    return PH_ERROR;
  endfunction

  function automatic res_t advance_phase(logic [3:0] cur, item_t ev);
    logic [3:0] nx;
    logic       ok;
    logic [7:0] c;
    res_t       r;
    c  = ev.handshake_code;
    nx = PH_ERROR;
    ok = 1'b0;
    case (ev.req_type)
      REQ_HS: begin
        // encrypted finished goes through the ccs rule
        if ((cur == PH_CCS_SENT && !ev.from_server) || (cur == PH_CCS_RECV && ev.from_server))
          nx = ccs_step(cur, ev.from_server);
        else if (ev.from_server) begin
          case (cur)
            PH_CH_SENT:   if (c == HS_SERVER_HELLO) nx = PH_SH_RECV;
            PH_SH_RECV: begin
              if (c == HS_CERTIFICATE) nx = PH_CERT_RECV;
              else if (c == HS_SERVER_KEX) nx = PH_SKE_RECV;
              else if (c == HS_CERT_REQUEST) nx = PH_CR_RECV;
              else if (c == HS_SERVER_DONE) nx = PH_SHD_RECV;
            end
            PH_CERT_RECV: begin
              if (c == HS_SERVER_KEX) nx = PH_SKE_RECV;
              else if (c == HS_CERT_REQUEST) nx = PH_CR_RECV;
              else if (c == HS_SERVER_DONE) nx = PH_SHD_RECV;
            end
            PH_SKE_RECV: begin
              if (c == HS_CERT_REQUEST) nx = PH_CR_RECV;
              else if (c == HS_SERVER_DONE) nx = PH_SHD_RECV;
            end
            PH_CR_RECV:   if (c == HS_SERVER_DONE) nx = PH_SHD_RECV;
            PH_FIN_SENT: begin
              if (c == HS_FINISHED) nx = PH_FIN_RECV;
              else if (c == HS_SESSION_TKT) nx = PH_FIN_SENT;
            end
            default: nx = PH_ERROR;
          endcase
        end else begin
          case (cur)
            PH_INIT:      if (c == HS_CLIENT_HELLO) nx = PH_CH_SENT;
            PH_SHD_RECV: begin
              if (c == HS_CERTIFICATE) nx = PH_CERT_SENT;
              else if (c == HS_CLIENT_KEX) nx = PH_CKE_SENT;
            end
            PH_CERT_SENT: begin
              if (c == HS_CLIENT_KEX) nx = PH_CKE_SENT;
              else if (c == HS_CERT_VERIFY) nx = PH_CV_SENT;
            end
            PH_CV_SENT:   if (c == HS_CLIENT_KEX) nx = PH_CKE_SENT;
            PH_CKE_SENT:  if (c == HS_FINISHED) nx = PH_FIN_SENT;
            default: nx = PH_ERROR;
          endcase
        end
        ok = (nx != PH_ERROR);
      end
      REQ_CCS: begin
        nx = ccs_step(cur, ev.from_server);
        ok = (nx != PH_ERROR);
      end
      REQ_RESTART: begin
        nx = PH_INIT;
        ok = 1'b1;
      end
      default: begin
        nx = cur;
        ok = 1'b0;
      end
    endcase
    r.phase       = nx;
    r.legal_event = ok;
    r.in_error    = (nx == PH_ERROR);
    r.done_res    = (nx == PH_COMPLETE);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      track_phase = PH_INIT;
      predicted_outcomes.delete();
      errs    = 0;
      checked = 0;
      legal   = 0;
      hits    = '0;
      mismatch_cnt_o <= 0;
      pending_cnt_o  <= 0;
      checked_cnt_o  <= 0;
      legal_cnt_o    <= 0;
      phases_hit_o   <= '0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.phase       = res_i.phase;
        got.legal_event = res_i.legal_event;
        got.in_error    = res_i.in_error;
        got.done_res    = res_i.done_res;
        if (predicted_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got phase %0d legal %0b",
                   $time, got.phase, got.legal_event);
          errs++;
        end else begin
          want = predicted_outcomes.pop_front();
          check_field("phase", want.phase, got.phase);
          check_field("legal_event", want.legal_event, got.legal_event);
          check_field("in_error", want.in_error, got.in_error);
          check_field("done_res", want.done_res, got.done_res);
          checked++;
          if (want.legal_event) legal++;
          hits[want.phase] = 1'b1;
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = advance_phase(track_phase,
                             '{req_type: req_i.req_type, from_server: req_i.from_server,
                               handshake_code: req_i.handshake_code});
        track_phase = want.phase;
        predicted_outcomes.push_back(want);
      end
      mismatch_cnt_o <= errs;
      pending_cnt_o  <= predicted_outcomes.size();
      checked_cnt_o  <= checked;
      legal_cnt_o    <= legal;
      phases_hit_o   <= hits;
    end
  end

endmodule

// File: tb/tb.sv
// stimulus and verdict for the tls 1.2 handshake tracker
`timescale 1ns / 100ps

module tb;
  import tls12ht_pkg::*;

  // request code the tracker must ignore
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  tls12ht_req_if req_if ();
  tls12ht_res_if res_if ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  int unsigned legal_cnt;
  logic [15:0] phases_hit;

  // stimulus knobs, also read by the result-side driver
  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned hold_len  = 0;
  int unsigned hold_cnt  = 0;
  int unsigned sent      = 0;

  always #6 clk_i = ~clk_i;

  tls12_handshake_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  tls12ht_phase_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .res_i          (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt),
    .checked_cnt_o  (checked_cnt),
    .legal_cnt_o    (legal_cnt),
    .phases_hit_o   (phases_hit)
  );

  function automatic item_t mk(logic [1:0] rt, logic srv, logic [7:0] code);
    item_t it;
    it.req_type       = rt;
    it.from_server    = srv;
    it.handshake_code = code;
    return it;
  endfunction

  // random event, half the time with a code the tracker knows
  function automatic item_t noise_item();
    logic [7:0] known[10];
    logic [7:0] code;
    known = '{HS_CLIENT_HELLO, HS_SERVER_HELLO, HS_SESSION_TKT, HS_CERTIFICATE,
              HS_SERVER_KEX, HS_CERT_REQUEST, HS_SERVER_DONE, HS_CERT_VERIFY,
              HS_CLIENT_KEX, HS_FINISHED};
    if ($urandom_range(0, 1) != 0) code = known[$urandom_range(0, 9)];
    else code = 8'($urandom_range(0, 255));
    return mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), code);
  endfunction

  // offer one request, holding valid and payload until it is taken
  task automatic issue(input item_t it);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 19) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= it.req_type;
    req_if.from_server    <= it.from_server;
    req_if.handshake_code <= it.handshake_code;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  // one step of a well-formed flow, now and then preceded by noise or dropped
  task automatic flow(input logic [1:0] rt, input logic srv, input logic [7:0] code);
    if ($urandom_range(0, 99) < 4) issue(noise_item());
    if ($urandom_range(0, 99) >= 3) issue(mk(rt, srv, code));
  endtask

  // sender stops and waits until every outstanding result has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // one full handshake with random optional messages and random ciphertext
  task automatic run_handshake();
    bit cert_req;
    bit cli_cert;
    int n_tkt;
    if ($urandom_range(0, 7) == 0) begin
      // a burst of pure noise
      repeat ($urandom_range(3, 12)) issue(noise_item());
      return;
    end
    if ($urandom_range(0, 3) != 0) flow(REQ_RESTART, 1'($urandom_range(0, 1)),
                                        8'($urandom_range(0, 255)));
    flow(REQ_HS, 1'b0, HS_CLIENT_HELLO);
    flow(REQ_HS, 1'b1, HS_SERVER_HELLO);
    if ($urandom_range(0, 1) != 0) flow(REQ_HS, 1'b1, HS_CERTIFICATE);
    if ($urandom_range(0, 1) != 0) flow(REQ_HS, 1'b1, HS_SERVER_KEX);
    cert_req = 1'($urandom_range(0, 1));
    if (cert_req) flow(REQ_HS, 1'b1, HS_CERT_REQUEST);
    flow(REQ_HS, 1'b1, HS_SERVER_DONE);
    // client certificate normally only after a certificate request
    cli_cert = (cert_req || $urandom_range(0, 9) == 0) && $urandom_range(0, 3) != 0;
    if (cli_cert) begin
      flow(REQ_HS, 1'b0, HS_CERTIFICATE);
      if ($urandom_range(0, 1) != 0) flow(REQ_HS, 1'b0, HS_CERT_VERIFY);
    end
    flow(REQ_HS, 1'b0, HS_CLIENT_KEX);
    if ($urandom_range(0, 4) != 0) begin
      flow(REQ_CCS, 1'b0, 8'($urandom_range(0, 255)));
      // encrypted finished: any type byte, or a second ccs record
      if ($urandom_range(0, 4) != 0) flow(REQ_HS, 1'b0, 8'($urandom_range(0, 255)));
      else flow(REQ_CCS, 1'b0, 8'($urandom_range(0, 255)));
    end else begin
      flow(REQ_HS, 1'b0, HS_FINISHED);
    end
    n_tkt = $urandom_range(0, 2);
    repeat (n_tkt) flow(REQ_HS, 1'b1, HS_SESSION_TKT);
    if ($urandom_range(0, 3) != 0) begin
      flow(REQ_CCS, 1'b1, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0) flow(REQ_HS, 1'b1, 8'($urandom_range(0, 255)));
      else flow(REQ_CCS, 1'b1, 8'($urandom_range(0, 255)));
    end else begin
      flow(REQ_HS, 1'b1, HS_FINISHED);
    end
    // completion by a ccs of either direction
    if ($urandom_range(0, 9) < 7) flow(REQ_CCS, 1'($urandom_range(0, 1)),
                                       8'($urandom_range(0, 255)));
    // stray trailing events, most of which land in the sticky error phase
    if ($urandom_range(0, 9) == 0) issue(noise_item());
    if ($urandom_range(0, 19) == 0) issue(mk(REQ_SPARE, 1'($urandom_range(0, 1)),
                                             8'($urandom_range(0, 255))));
  endtask

  // result-side ready: random stalls, stall-free stretches and long hold-offs
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        res_if.ready <= 1'b0;
        hold_len--;
      end else if (stalls_on && $urandom_range(0, 99) < 19) begin
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.req_type       <= REQ_HS;
    req_if.from_server    <= 1'b0;
    req_if.handshake_code <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: the full mutual-auth flow, then every special case
    issue(mk(REQ_RESTART, 1'b1, 8'hff));
    issue(mk(REQ_HS, 1'b0, HS_CLIENT_HELLO));
    issue(mk(REQ_HS, 1'b1, HS_SERVER_HELLO));
    issue(mk(REQ_HS, 1'b1, HS_CERTIFICATE));
    issue(mk(REQ_HS, 1'b1, HS_SERVER_KEX));
    issue(mk(REQ_HS, 1'b1, HS_CERT_REQUEST));
    issue(mk(REQ_HS, 1'b1, HS_SERVER_DONE));
    issue(mk(REQ_HS, 1'b0, HS_CERTIFICATE));
    issue(mk(REQ_HS, 1'b0, HS_CERT_VERIFY));
    issue(mk(REQ_HS, 1'b0, HS_CLIENT_KEX));
    issue(mk(REQ_CCS, 1'b0, 8'h00));
    // encrypted finished from the client, type byte all ones
    issue(mk(REQ_HS, 1'b0, 8'hff));
    // session ticket keeps the phase
    issue(mk(REQ_HS, 1'b1, HS_SESSION_TKT));
    issue(mk(REQ_CCS, 1'b1, 8'h5a));
    // encrypted finished from the server, type byte all zeros
    issue(mk(REQ_HS, 1'b1, 8'h00));
    // ccs in finished-received completes the handshake
    issue(mk(REQ_CCS, 1'b0, 8'ha5));
    // anything after completion is an error, and the error sticks
    issue(mk(REQ_HS, 1'b1, HS_FINISHED));
    issue(mk(REQ_CCS, 1'b1, 8'h00));
    // unused request code is ignored
    issue(mk(REQ_SPARE, 1'b1, 8'hff));
    issue(mk(REQ_RESTART, 1'b0, 8'h00));
    issue(mk(REQ_SPARE, 1'b0, 8'h00));
    issue(mk(REQ_HS, 1'b1, HS_SERVER_HELLO));
    issue(mk(REQ_RESTART, 1'b0, 8'h00));
    drain();

    // random handshakes with gaps and stalls on both sides
    while (sent < 400) run_handshake();

    // receiver holds off while the sender keeps offering back to back
    gaps_on  = 1'b0;
    hold_len = 60;
    hold_cnt++;
    while (sent < 480) run_handshake();
    gaps_on = 1'b1;
    while (sent < 700) run_handshake();

    // a stretch with no idling on either side
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (sent < 900) run_handshake();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // sender pause until everything is back, then a second hold-off
    drain();
    gaps_on  = 1'b0;
    hold_len = 40;
    hold_cnt++;
    while (sent < 1000) run_handshake();
    gaps_on = 1'b1;
    while (sent < 1370) run_handshake();

    // let the tracker settle and catch any late or extra result
    drain();
    repeat (8) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked, %0d of them legal events",
             sent, checked_cnt, legal_cnt);
    $display("%0d of 16 phases reached, %0d long result-side hold-offs",
             $countones(phases_hit), hold_cnt);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
